// ===== design/tksi_pkg.sv =====
// ----------------------------------------------------------------------------
// tksi_pkg: shared types and constants for the top-K sorted insertion list
// Field widths, the item kind codes and the cell-to-cell link record.
// ----------------------------------------------------------------------------
package tksi_pkg;

    localparam int SCORE_W = 24;
    localparam int TAG_W   = 32;
    localparam int IDX_W   = 4;
    localparam int RANK_W  = 5;
    localparam int COUNT_W = 5;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } slot_t;

    // What one cell hands to the next one down the chain
    typedef struct packed {
        slot_t slot;
        logic  ge;      // cell holds a valid score >= the offered score
    } cell_link_t;

endpackage

// ===== design/top_k_sorted_insert.sv =====
// ----------------------------------------------------------------------------
// top_k_sorted_insert: keeps the LIST_DEPTH best scores with their tags
// A chain of cells compares every slot with the offered score in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_stall): kind selects insert or read. An insert
//   offers new_score/entry_tag; a read returns the slot at read_index.
//   Output beat (out_valid/out_stall): one result per input beat: rank
//   (1-based, 0 if rejected or a read), entry_count after the beat, and on a
//   valid read the score and tag at read_index (zero otherwise).
//   The result is registered at the edge that accepts the input beat.
//   Throughput is one beat per cycle while out_stall does not hold a result,
//   set by the single compare-and-shift step of the cell chain.
//   Ties keep the older entry first; a full list rejects scores not above its
//   last entry, and an accepted insert drops the bottom entry.
//   While a result is held by out_stall, in_stall is raised and no new beat
//   enters; the held result does not change.
//   Reset empties the list and clears any pending result.
// ----------------------------------------------------------------------------
module top_k_sorted_insert
    import tksi_pkg::*;
#(
    parameter int LIST_DEPTH = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [SCORE_W-1:0] new_score,
    input  logic [TAG_W-1:0]   entry_tag,
    input  logic [IDX_W-1:0]   read_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [RANK_W-1:0]  rank,
    output logic [COUNT_W-1:0] entry_count,
    output logic               read_valid,
    output logic [SCORE_W-1:0] read_score,
    output logic [TAG_W-1:0]   read_tag
);

    cell_link_t         link [LIST_DEPTH+1];
    logic               accept;
    logic               is_read;
    logic               ins_en;
    logic [COUNT_W-1:0] ge_count;
    logic [COUNT_W-1:0] valid_count;
    logic               hit_valid;
    logic [SCORE_W-1:0] hit_score;
    logic [TAG_W-1:0]   hit_tag;
    logic [LIST_DEPTH-1:0] valid_vec;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rank_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               rvalid_reg;
    logic               rvalid_next;
    logic [SCORE_W-1:0] rscore_reg;
    logic [SCORE_W-1:0] rscore_next;
    logic [TAG_W-1:0]   rtag_reg;
    logic [TAG_W-1:0]   rtag_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_read  = (kind == KIND_READ);

    // Head of the chain: a full, top-scoring sentinel, so cell 0 always
    // takes the new entry when it does not keep its own
    assign link[0].slot.valid = 1'b1;
    assign link[0].slot.score = {SCORE_W{1'b1}};
    assign link[0].slot.tag   = '0;
    assign link[0].ge         = 1'b1;

    // Taken when the bottom cell is empty or holds a lower score
    assign ins_en = accept && !is_read && !link[LIST_DEPTH].ge;

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        tksi_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ins_en    (ins_en),
            .new_score (new_score),
            .new_tag   (entry_tag),
            .link_in   (link[i]),
            .link_out  (link[i+1])
        );
        assign valid_vec[i] = link[i+1].slot.valid;
    end

    always_comb
    begin
        ge_count    = '0;
        valid_count = '0;
        hit_valid   = 1'b0;
        hit_score   = '0;
        hit_tag     = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            ge_count    = ge_count + COUNT_W'(link[i+1].ge);
            valid_count = valid_count + COUNT_W'(link[i+1].slot.valid);
            if (read_index == IDX_W'(i) && link[i+1].slot.valid)
            begin
                hit_valid = 1'b1;
                hit_score = link[i+1].slot.score;
                hit_tag   = link[i+1].slot.tag;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        rank_next      = rank_reg;
        count_next     = count_reg;
        rvalid_next    = rvalid_reg;
        rscore_next    = rscore_reg;
        rtag_next      = rtag_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            rank_next      = ins_en ? RANK_W'(ge_count + COUNT_W'(1)) : '0;
            count_next     = valid_count
                           + COUNT_W'(ins_en && !link[LIST_DEPTH].slot.valid);
            rvalid_next    = is_read && hit_valid;
            rscore_next    = is_read ? hit_score : '0;
            rtag_next      = is_read ? hit_tag : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg   <= rank_next;
        count_reg  <= count_next;
        rvalid_reg <= rvalid_next;
        rscore_reg <= rscore_next;
        rtag_reg   <= rtag_next;
    end

    assign out_valid   = out_valid_reg;
    assign rank        = rank_reg;
    assign entry_count = count_reg;
    assign read_valid  = rvalid_reg;
    assign read_score  = rscore_reg;
    assign read_tag    = rtag_reg;

    // Reported count matches the cells once the beat has landed
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == valid_count))
        else $error("top_k_sorted_insert: entry_count differs from cell contents");

    // A rank never lies beyond the entries that exist
    a_rank_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rank_reg <= count_reg))
        else $error("top_k_sorted_insert: rank beyond entry count");

    // A read never reports a rank, and valid read data needs a filled slot
    a_read_no_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rvalid_reg) |-> (rank_reg == '0 && count_reg != '0))
        else $error("top_k_sorted_insert: read beat carries a rank");

    // Valid cells form a solid run from the top
    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + LIST_DEPTH'(1))) == '0))
        else $error("top_k_sorted_insert: gap in the list");

endmodule

// ===== design/tksi_cell.sv =====
// ----------------------------------------------------------------------------
// tksi_cell: one slot of the sorted list
// Holds a score and tag; on an insert it keeps, takes the new entry, or takes
// the entry of the cell above, which shifts the list down by one place.
// ----------------------------------------------------------------------------
module tksi_cell
    import tksi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ins_en,
    input  logic [SCORE_W-1:0] new_score,
    input  logic [TAG_W-1:0]   new_tag,
    input  cell_link_t         link_in,
    output cell_link_t         link_out
);

    logic               valid_reg;
    logic               valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic               keep;

    assign keep = valid_reg && (score_reg >= new_score);

    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ins_en && !keep)
        begin
            if (link_in.ge)
            begin
                // insertion point: everything above stays
                valid_next = 1'b1;
                score_next = new_score;
                tag_next   = new_tag;
            end
            else
            begin
                // shift down from the cell above
                valid_next = link_in.slot.valid;
                score_next = link_in.slot.score;
                tag_next   = link_in.slot.tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign link_out.slot.valid = valid_reg;
    assign link_out.slot.score = score_reg;
    assign link_out.slot.tag   = tag_reg;
    assign link_out.ge         = keep;

    // Entries fill from the top with no gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> link_in.slot.valid)
        else $error("tksi_cell: valid slot below an empty one");

    // List stays in descending order
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && link_in.slot.valid) |-> (link_in.slot.score >= score_reg))
        else $error("tksi_cell: list out of order");

endmodule

// ===== tb/top_k_sorted_insert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_tb: self-checking bench for the top-K sorted list
// Drives insert and read beats with random gaps and output stalls, keeps its
// own copy of the list to predict each result, and checks results in order.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_tb;
    import tksi_pkg::*;

    localparam int DEPTH        = 10;
    localparam int RANDOM_BEATS = 1550;
    localparam int TAIL_BEATS   = 150;
    localparam int STUCK_LIMIT  = 2000;

    typedef struct {
        kind_t              kind;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic [IDX_W-1:0]   idx;
        bit                 drain_first;    // hold until every result is in
    } offer_t;

    typedef struct {
        logic [RANK_W-1:0]  rank;
        logic [COUNT_W-1:0] count;
        logic               rvalid;
        logic [SCORE_W-1:0] rscore;
        logic [TAG_W-1:0]   rtag;
    } board_result_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               kind        = 1'b0;
    logic [SCORE_W-1:0] new_score   = '0;
    logic [TAG_W-1:0]   entry_tag   = '0;
    logic [IDX_W-1:0]   read_index  = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [RANK_W-1:0]  rank;
    logic [COUNT_W-1:0] entry_count;
    logic               read_valid;
    logic [SCORE_W-1:0] read_score;
    logic [TAG_W-1:0]   read_tag;

    offer_t        queued_offers[$];
    board_result_t awaited_results[$];

    // Shadow copy of the list
    logic [SCORE_W-1:0] board_score[DEPTH];
    logic [TAG_W-1:0]   board_tag[DEPTH];
    int                 board_fill = 0;

    logic in_taken    = 1'b0;
    int   in_gap      = 0;
    int   stall_left  = 0;
    int   quiet_ticks = 0;
    int   mismatches  = 0;

    top_k_sorted_insert #(
        .LIST_DEPTH (DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .new_score   (new_score),
        .entry_tag   (entry_tag),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rank        (rank),
        .entry_count (entry_count),
        .read_valid  (read_valid),
        .read_score  (read_score),
        .read_tag    (read_tag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic board_result_t update_leaderboard(kind_t k, logic [SCORE_W-1:0] s,
                                                         logic [TAG_W-1:0] t,
                                                         logic [IDX_W-1:0] idx);
        board_result_t r;
        int            pos;
        int            i;
        bit            accept;
        r = '{default: '0};
        if (k == KIND_INSERT)
        begin
            accept = (board_fill < DEPTH) ||
                     (board_fill > 0 && s > board_score[board_fill-1]);
            if (accept)
            begin
                pos = 0;
                while (pos < board_fill && board_score[pos] >= s)
                    pos++;
                if (board_fill < DEPTH)
                    board_fill++;
                // shift lower entries down, the bottom one falls off when full
                for (i = board_fill - 1; i > pos; i--)
                begin
                    board_score[i] = board_score[i-1];
                    board_tag[i]   = board_tag[i-1];
                end
                board_score[pos] = s;
                board_tag[pos]   = t;
                r.rank = RANK_W'(pos + 1);
            end
        end
        else if (int'(idx) < board_fill)
        begin
            r.rvalid = 1'b1;
            r.rscore = board_score[idx];
            r.rtag   = board_tag[idx];
        end
        r.count = COUNT_W'(board_fill);
        return r;
    endfunction

    function automatic void add_insert(logic [SCORE_W-1:0] s, logic [TAG_W-1:0] t,
                                       bit drain);
        offer_t o;
        o.kind        = KIND_INSERT;
        o.score       = s;
        o.tag         = t;
        o.idx         = IDX_W'($urandom);
        o.drain_first = drain;
        queued_offers = {queued_offers, o};
    endfunction

    function automatic void add_read(logic [IDX_W-1:0] idx, bit drain);
        offer_t o;
        o.kind        = KIND_READ;
        o.score       = SCORE_W'($urandom);
        o.tag         = $urandom;
        o.idx         = idx;
        o.drain_first = drain;
        queued_offers = {queued_offers, o};
    endfunction

    // Driver: present beats at the falling edge, hold a stalled beat
    always @(negedge clk)
    begin
        offer_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (in_gap != 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (queued_offers.size() != 0 &&
                         !(queued_offers[0].drain_first && awaited_results.size() != 0))
                begin
                    nxt = queued_offers.pop_front();
                    in_valid   <= 1'b1;
                    kind       <= nxt.kind;
                    new_score  <= nxt.score;
                    entry_tag  <= nxt.tag;
                    read_index <= nxt.idx;
                    if (queued_offers.size() > TAIL_BEATS && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 8);
                end
                else
                    in_valid <= 1'b0;
            end

            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (queued_offers.size() > TAIL_BEATS && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 7);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: check the result beat, then predict for the input beat
    always @(posedge clk)
    begin
        board_result_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;

            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rank !== want.rank)
                    begin
                        $error("rank: expected %0d, got %0d", want.rank, rank);
                        mismatches++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                        mismatches++;
                    end
                    if (read_valid !== want.rvalid)
                    begin
                        $error("read_valid: expected %0d, got %0d", want.rvalid, read_valid);
                        mismatches++;
                    end
                    if (read_score !== want.rscore)
                    begin
                        $error("read_score: expected %0h, got %0h", want.rscore, read_score);
                        mismatches++;
                    end
                    if (read_tag !== want.rtag)
                    begin
                        $error("read_tag: expected %0h, got %0h", want.rtag, read_tag);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
                awaited_results = {awaited_results,
                                   update_leaderboard(kind_t'(kind), new_score,
                                                      entry_tag, read_index)};

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_ticks = 0;
            else
                quiet_ticks++;
            if (quiet_ticks >= STUCK_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int                 n;
        logic [SCORE_W-1:0] s;

        // Empty list reads, both ends of the index
        add_read(4'd0, 1'b0);
        add_read(4'd15, 1'b0);
        // Extremes of score and tag
        add_insert(24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
        add_insert(24'h000000, 32'h0000_0000, 1'b0);
        // Ties keep the older entry first
        add_insert(24'd500, 32'hA000_0001, 1'b0);
        add_insert(24'd500, 32'hA000_0002, 1'b0);
        add_insert(24'd500, 32'hA000_0003, 1'b0);
        add_insert(24'd1000, 32'hB000_0000, 1'b0);
        add_insert(24'd300, 32'hC000_0001, 1'b0);
        add_insert(24'd300, 32'hC000_0002, 1'b0);
        add_insert(24'd700, 32'hD000_0000, 1'b0);
        add_insert(24'd1, 32'hE000_0001, 1'b0);
        // Full now: equal to the last is rejected, one above it gets in
        add_insert(24'd0, 32'h1234_5678, 1'b0);
        add_insert(24'd1, 32'hE000_0002, 1'b0);
        add_insert(24'd1, 32'hE000_0003, 1'b0);
        add_insert(24'd2, 32'hF000_0000, 1'b0);
        add_insert(24'hFFFFFF, 32'h5555_AAAA, 1'b0);
        // Reads inside the list, at its end and beyond the depth
        add_read(4'd0, 1'b0);
        add_read(4'd1, 1'b0);
        add_read(4'd5, 1'b0);
        add_read(4'd9, 1'b0);
        add_read(4'd10, 1'b0);
        add_read(4'd15, 1'b0);

        // Scores ride a rising ramp so the full list keeps accepting, with ties
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if ($urandom_range(0, 9) < 3)
                add_read(IDX_W'($urandom_range(0, 15)), n % 300 == 0);
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    s = SCORE_W'($urandom);
                else
                    s = SCORE_W'(((n + $urandom_range(0, 8)) >> 2) * 40000
                                 + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0));
                add_insert(s, $urandom, n % 300 == 0);
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(queued_offers.size() == 0 && !in_valid && awaited_results.size() == 0))
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tksi_pkg.sv
design/tksi_cell.sv
design/top_k_sorted_insert.sv
tb/top_k_sorted_insert_tb.sv
